// File: rtl/ktidl_pkg.sv
// ----------------------------------------------------------------------------
// Keyed table package
// Shared constants, codes, types and the key normalization function.
// ----------------------------------------------------------------------------
package ktidl_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_BYTES = 8;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_DELETE = 2'd2;
	localparam logic [1:0] FN_MEMBER = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic occ;
		logic shift;
		logic load;
	} cell_ctrl_t;

	// A key ends at its first zero byte or after KEY_BYTES bytes.
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		logic             alive;
		r     = '0;
		alive = 1'b1;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (k[8*i +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[8*i +: 8] = k[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/ktidl_req_if.sv
// ----------------------------------------------------------------------------
// Keyed table request channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface ktidl_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        func;
	logic [ktidl_pkg::KEY_W-1:0]       key;
	logic signed [ktidl_pkg::VAL_W-1:0] value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink (input valid, input func, input key, input value, output ready);
endinterface

// File: rtl/ktidl_rsp_if.sv
// ----------------------------------------------------------------------------
// Keyed table response channel
// Valid/ready channel carrying the result of one table operation.
// ----------------------------------------------------------------------------
interface ktidl_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [ktidl_pkg::VAL_W-1:0] result_value;
	logic                               found;
	logic [1:0]                         status;
	logic [ktidl_pkg::CNT_W-1:0]        entry_count;
	logic                               is_empty;
	logic                               is_full;

	modport source (output valid, output result_value, output found, output status,
		output entry_count, output is_empty, output is_full, input ready);
	modport sink (input valid, input result_value, input found, input status,
		input entry_count, input is_empty, input is_full, output ready);
endinterface

// File: rtl/ktidl_cell.sv
// ----------------------------------------------------------------------------
// Keyed table cell
// Holds one entry, compares it with the request key and takes the entry of
// its upper neighbor when a delete closes the gap.
// ----------------------------------------------------------------------------
module ktidl_cell (
	input  logic                          clk,
	input  ktidl_pkg::cell_ctrl_t         ctrl,
	input  logic [ktidl_pkg::KEY_W-1:0]   key,
	input  logic [ktidl_pkg::VAL_W-1:0]   value,
	input  logic [ktidl_pkg::KEY_W-1:0]   next_key,
	input  logic [ktidl_pkg::VAL_W-1:0]   next_value,
	output logic [ktidl_pkg::KEY_W-1:0]   cell_key,
	output logic [ktidl_pkg::VAL_W-1:0]   cell_value,
	output logic                          match
);

	logic [ktidl_pkg::KEY_W-1:0] key_q;
	logic [ktidl_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= next_key;
			value_q <= next_value;
		end else if (ctrl.load) begin
			key_q   <= key;
			value_q <= value;
		end
	end

	assign match      = ctrl.occ && (key_q == key);
	assign cell_key   = key_q;
	assign cell_value = value_q;

endmodule

// File: rtl/keyed_table_insert_delete_lookup.sv
// ----------------------------------------------------------------------------
// Keyed table with insert, delete and lookup
// Compacted key-value table in a row of cells searched in parallel.
// ----------------------------------------------------------------------------
// Requests are registered, then applied and loaded into the response register.
// A new request is taken only once the last is applied; the request register is
// freed only when the table update and the response load happen together.
// Reset empties the table and sets the undefined value to -1; the entry
// storage itself is not cleared.
module keyed_table_insert_delete_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	ktidl_req_if.sink                           req,
	ktidl_rsp_if.source                         rsp,
	input  logic                                cfg_we,
	input  logic [ktidl_pkg::VAL_W-1:0]         cfg_wdata
);

	localparam int N = ktidl_pkg::CAPACITY;

	logic [ktidl_pkg::VAL_W-1:0] undef_q;
	logic [ktidl_pkg::CNT_W-1:0] count_q;

	logic                        req_v_s1;
	logic [1:0]                  func_s1;
	logic [ktidl_pkg::KEY_W-1:0] key_s1;
	logic [ktidl_pkg::VAL_W-1:0] value_s1;

	logic                        rsp_v_q;
	logic [ktidl_pkg::VAL_W-1:0] result_q;
	logic                        found_q;
	logic [1:0]                  status_q;
	logic [ktidl_pkg::CNT_W-1:0] ecount_q;

	logic [N-1:0]                match_vec;
	logic [N-1:0]                above_vec;
	logic [ktidl_pkg::KEY_W-1:0] cell_key  [N];
	logic [ktidl_pkg::VAL_W-1:0] cell_value[N];
	ktidl_pkg::cell_ctrl_t       ctrl      [N];

	logic                        fire;
	logic                        hit;
	logic                        full;
	logic                        ins_do;
	logic                        del_do;
	logic [ktidl_pkg::VAL_W-1:0] hit_value;
	logic [1:0]                  status_d;
	logic [ktidl_pkg::CNT_W-1:0] count_d;

	assign req.ready = !req_v_s1;
	assign fire      = req_v_s1 && (!rsp_v_q || rsp.ready);
	assign hit       = |match_vec;
	assign full      = (count_q == ktidl_pkg::CNT_W'(N));
	assign ins_do    = (func_s1 == ktidl_pkg::FN_INSERT) && !hit && !full;
	assign del_do    = (func_s1 == ktidl_pkg::FN_DELETE) && hit;
	assign above_vec = ~(match_vec - N'(1));

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1  <= req.func;
			key_s1   <= ktidl_pkg::norm_key(req.key);
			value_s1 <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			req_v_s1 <= 1'b1;
		end else if (fire) begin
			req_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undef_q <= '1;
		end else if (cfg_we) begin
			undef_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign ctrl[i].occ   = (ktidl_pkg::CNT_W'(i) < count_q);
		assign ctrl[i].shift = fire && del_do && above_vec[i];
		assign ctrl[i].load  = fire && ins_do && (count_q == ktidl_pkg::CNT_W'(i));

		if (i == N - 1) begin : g_last
			ktidl_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.key       (key_s1),
				.value     (value_s1),
				.next_key  (cell_key[i]),
				.next_value(cell_value[i]),
				.cell_key  (cell_key[i]),
				.cell_value(cell_value[i]),
				.match     (match_vec[i])
			);
		end else begin : g_mid
			ktidl_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.key       (key_s1),
				.value     (value_s1),
				.next_key  (cell_key[i+1]),
				.next_value(cell_value[i+1]),
				.cell_key  (cell_key[i]),
				.cell_value(cell_value[i]),
				.match     (match_vec[i])
			);
		end
	end

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < N; i++) begin
			hit_value = hit_value | (cell_value[i] & {ktidl_pkg::VAL_W{match_vec[i]}});
		end
	end

	always_comb begin
		count_d = count_q;
		case (func_s1)
			ktidl_pkg::FN_LOOKUP, ktidl_pkg::FN_MEMBER: begin
				status_d = hit ? ktidl_pkg::ST_OK : ktidl_pkg::ST_MISSING;
			end
			ktidl_pkg::FN_INSERT: begin
				if (hit) begin
					status_d = ktidl_pkg::ST_PRESENT;
				end else if (full) begin
					status_d = ktidl_pkg::ST_FULL;
				end else begin
					status_d = ktidl_pkg::ST_OK;
					count_d  = count_q + ktidl_pkg::CNT_W'(1);
				end
			end
			ktidl_pkg::FN_DELETE: begin
				if (hit) begin
					status_d = ktidl_pkg::ST_OK;
					count_d  = count_q - ktidl_pkg::CNT_W'(1);
				end else begin
					status_d = ktidl_pkg::ST_MISSING;
				end
			end
			default: begin
				status_d = ktidl_pkg::ST_MISSING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_v_q <= 1'b0;
		end else if (fire) begin
			count_q <= count_d;
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= hit ? hit_value : undef_q;
			found_q  <= hit;
			status_q <= status_d;
			ecount_q <= count_d;
		end
	end

	assign rsp.valid        = rsp_v_q;
	assign rsp.result_value = result_q;
	assign rsp.found        = found_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = ecount_q;
	assign rsp.is_empty     = (ecount_q == '0);
	assign rsp.is_full      = (ecount_q == ktidl_pkg::CNT_W'(N));

endmodule

// File: rtl/ktidl_chk.sv
// ----------------------------------------------------------------------------
// Keyed table port checker
// Checks response consistency and request pacing seen at the top level ports.
// ----------------------------------------------------------------------------
module ktidl_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        found,
	input logic [1:0]                  status,
	input logic [ktidl_pkg::CNT_W-1:0] entry_count,
	input logic                        is_empty,
	input logic                        is_full
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Response dropped while stalled.");

	a_req_pace: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while another is in flight.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)))
		else $error("Empty flag disagrees with entry count.");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_full == (entry_count == ktidl_pkg::CNT_W'(ktidl_pkg::CAPACITY))))
		else $error("Full flag disagrees with entry count.");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (found ? (status == ktidl_pkg::ST_OK || status == ktidl_pkg::ST_PRESENT)
			: (status != ktidl_pkg::ST_PRESENT)))
		else $error("Status does not agree with the found flag.");

endmodule

bind keyed_table_insert_delete_lookup ktidl_chk u_ktidl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.found      (rsp.found),
	.status     (rsp.status),
	.entry_count(rsp.entry_count),
	.is_empty   (rsp.is_empty),
	.is_full    (rsp.is_full)
);

// File: tb/tb_keyed_table_insert_delete_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed table testbench
// Drives lookup, insert, delete and member test requests into the table and
// checks every response against a shadow copy of the table kept in the
// bench. Covers string key termination, the full and empty table, the
// undefined value register at its extremes, bursty requests and a stalling
// response side, including a long hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_keyed_table_insert_delete_lookup;

	localparam int POOL_SIZE   = 96;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic signed [ktidl_pkg::VAL_W-1:0] result_value;
		logic                               found;
		logic [1:0]                         status;
		logic [ktidl_pkg::CNT_W-1:0]        entry_count;
		logic                               is_empty;
		logic                               is_full;
	} table_rsp_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [ktidl_pkg::VAL_W-1:0] cfg_wdata;

	ktidl_req_if req_ch();
	ktidl_rsp_if rsp_ch();

	keyed_table_insert_delete_lookup u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the table contents and the undefined value register.
	logic [ktidl_pkg::KEY_W-1:0] shadow_keys[$];
	logic [ktidl_pkg::VAL_W-1:0] shadow_vals[$];
	logic [ktidl_pkg::VAL_W-1:0] shadow_undef;

	table_rsp_t                  rsp_due[$];
	table_rsp_t                  rsp_want;
	logic [ktidl_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

	int  errors;
	int  rsp_seen;
	int  cycles;
	int  burst_left;
	bit  steady_send;
	int  hold_len;
	int  hold_serial;
	int  hold_done;
	int  hold_left;
	int  stretch_left;
	int  rx_mode;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Keys compare as strings: everything from the first zero byte on is dropped.
	function automatic logic [ktidl_pkg::KEY_W-1:0] key_string(
			input logic [ktidl_pkg::KEY_W-1:0] k);
		logic [ktidl_pkg::KEY_W-1:0] keep;
		bit                          ended;
		keep  = '0;
		ended = 1'b0;
		for (int b = 0; b < ktidl_pkg::KEY_BYTES; b++) begin
			ended = ended || (k[8*b +: 8] == 8'h00);
			if (!ended) begin
				keep[8*b +: 8] = 8'hFF;
			end
		end
		return k & keep;
	endfunction

	function automatic table_rsp_t table_apply(input logic [1:0] f,
			input logic [ktidl_pkg::KEY_W-1:0] k_raw, input logic [ktidl_pkg::VAL_W-1:0] v);
		table_rsp_t                  r;
		logic [ktidl_pkg::KEY_W-1:0] k;
		int                          pos;
		k   = key_string(k_raw);
		pos = -1;
		foreach (shadow_keys[i]) begin
			if (pos < 0 && shadow_keys[i] == k) begin
				pos = i;
			end
		end
		r.found        = (pos >= 0);
		r.result_value = shadow_undef;
		if (pos >= 0) begin
			r.result_value = shadow_vals[pos];
		end
		case (f)
			ktidl_pkg::FN_INSERT: begin
				if (r.found) begin
					r.status = ktidl_pkg::ST_PRESENT;
				end else if (shadow_keys.size() >= ktidl_pkg::CAPACITY) begin
					r.status = ktidl_pkg::ST_FULL;
				end else begin
					shadow_keys.push_back(k);
					shadow_vals.push_back(v);
					r.status = ktidl_pkg::ST_OK;
				end
			end
			ktidl_pkg::FN_DELETE: begin
				if (r.found) begin
					shadow_keys.delete(pos);
					shadow_vals.delete(pos);
					r.status = ktidl_pkg::ST_OK;
				end else begin
					r.status = ktidl_pkg::ST_MISSING;
				end
			end
			default: begin
				r.status = r.found ? ktidl_pkg::ST_OK : ktidl_pkg::ST_MISSING;
			end
		endcase
		r.entry_count = ktidl_pkg::CNT_W'(shadow_keys.size());
		r.is_empty    = (shadow_keys.size() == 0);
		r.is_full     = (shadow_keys.size() == ktidl_pkg::CAPACITY);
		return r;
	endfunction

	// Random garbage after the terminator must not change the key.
	function automatic logic [ktidl_pkg::KEY_W-1:0] dress_key(
			input logic [ktidl_pkg::KEY_W-1:0] base);
		logic [ktidl_pkg::KEY_W-1:0] k;
		int                          len;
		k   = base;
		len = 0;
		while (len < ktidl_pkg::KEY_BYTES && base[8*len +: 8] != 8'h00) begin
			len++;
		end
		if (len < ktidl_pkg::KEY_BYTES - 1 && $urandom_range(0, 1) == 1) begin
			for (int b = len + 1; b < ktidl_pkg::KEY_BYTES; b++) begin
				k[8*b +: 8] = 8'($urandom_range(0, 255));
			end
		end
		return k;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR: response %0d %s: got 0x%0h, expected 0x%0h",
			rsp_seen, what, got, want);
		errors++;
	endtask

	task automatic send_request(input logic [1:0] f, input logic [ktidl_pkg::KEY_W-1:0] k,
			input logic [ktidl_pkg::VAL_W-1:0] v);
		int gap;
		gap = 0;
		if (!steady_send) begin
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(1, 8);
			end
			burst_left--;
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.key   <= k;
		req_ch.value <= v;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		rsp_due.push_back(table_apply(f, k, v));
	endtask

	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (rsp_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic send_random(input int ins_pct);
		logic [ktidl_pkg::KEY_W-1:0] k;
		logic [1:0]                  f;
		int                          r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			send_request(2'($urandom_range(0, 3)), {$urandom(), $urandom()}, $urandom());
		end else begin
			k = dress_key(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
			r = $urandom_range(0, 99);
			if (r < ins_pct) begin
				f = ktidl_pkg::FN_INSERT;
			end else if (r < ins_pct + (100 - ins_pct) / 2) begin
				f = ktidl_pkg::FN_DELETE;
			end else if (r[0]) begin
				f = ktidl_pkg::FN_LOOKUP;
			end else begin
				f = ktidl_pkg::FN_MEMBER;
			end
			send_request(f, k, $urandom());
		end
	endtask

	task automatic test_directed();
		send_request(ktidl_pkg::FN_LOOKUP, 64'h0, 32'h0);
		send_request(ktidl_pkg::FN_MEMBER, 64'h0000_0000_0000_0041, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_request(ktidl_pkg::FN_INSERT, 64'h0, 32'h7FFF_FFFF);
		send_request(ktidl_pkg::FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
		send_request(ktidl_pkg::FN_INSERT, 64'h0000_0000_0000_6261, 32'h0);
		send_request(ktidl_pkg::FN_INSERT, 64'hDEAD_BEEF_0000_6261, 32'h1234_5678);
		send_request(ktidl_pkg::FN_LOOKUP, 64'h0102_0304_0500_6261, 32'h0);
		send_request(ktidl_pkg::FN_MEMBER, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_request(ktidl_pkg::FN_LOOKUP, 64'h1122_3344_5566_7700, 32'h0);
		send_request(ktidl_pkg::FN_INSERT, 64'h8000_0000_0000_0080, 32'hFFFF_FFFF);
		send_request(ktidl_pkg::FN_LOOKUP, 64'h0000_0000_0000_0080, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, 64'h5500_0000_0000_0000, 32'h0);
		send_request(ktidl_pkg::FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_request(ktidl_pkg::FN_MEMBER, 64'h0, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, 64'h0000_0000_0000_6261, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, 64'h0000_0000_0000_6261, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, 64'h0000_0000_0000_0080, 32'h0);
		send_request(ktidl_pkg::FN_LOOKUP, 64'h0000_0000_0000_0080, 32'h0);
	endtask

	task automatic test_fill_table();
		logic [ktidl_pkg::KEY_W-1:0] fill_keys[$];
		logic [ktidl_pkg::KEY_W-1:0] k;
		logic [ktidl_pkg::KEY_W-1:0] extra_key;
		int                          j;
		for (int i = 0; i < ktidl_pkg::CAPACITY; i++) begin
			for (int b = 1; b < ktidl_pkg::KEY_BYTES; b++) begin
				k[8*b +: 8] = 8'($urandom_range(1, 255));
			end
			k[7:0] = 8'(i + 1);
			fill_keys.push_back(k);
			send_request(ktidl_pkg::FN_INSERT, k, $urandom());
		end
		extra_key = {$urandom(), $urandom()} | 64'hFF;
		send_request(ktidl_pkg::FN_INSERT, extra_key, $urandom());
		send_request(ktidl_pkg::FN_INSERT, fill_keys[10], $urandom());
		send_request(ktidl_pkg::FN_LOOKUP, fill_keys[ktidl_pkg::CAPACITY - 1], 32'h0);
		send_request(ktidl_pkg::FN_MEMBER, extra_key, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, extra_key, 32'h0);
		send_request(ktidl_pkg::FN_DELETE, fill_keys[20], 32'h0);
		send_request(ktidl_pkg::FN_LOOKUP, fill_keys[21], 32'h0);
		send_request(ktidl_pkg::FN_LOOKUP, fill_keys[20], 32'h0);
		send_request(ktidl_pkg::FN_INSERT, extra_key, 32'h8000_0000);
		send_request(ktidl_pkg::FN_INSERT, fill_keys[20], $urandom());
		fill_keys[20] = extra_key;
		while (fill_keys.size() != 0) begin
			j = $urandom_range(0, fill_keys.size() - 1);
			send_request(ktidl_pkg::FN_DELETE, fill_keys[j], 32'h0);
			fill_keys.delete(j);
			if (fill_keys.size() != 0 && $urandom_range(0, 3) == 0) begin
				send_request(ktidl_pkg::FN_LOOKUP,
					fill_keys[$urandom_range(0, fill_keys.size() - 1)], 32'h0);
			end
		end
	endtask

	task automatic test_backpressure();
		steady_send = 1'b1;
		hold_len    = 400;
		hold_serial++;
		repeat (48) send_random(40);
		steady_send = 1'b0;
	endtask

	task automatic test_pause();
		repeat (30) send_random(40);
		drain_requests();
		repeat (30) send_random(40);
	endtask

	task automatic test_random_mix(input int count, input int ins_pct,
			input logic [ktidl_pkg::VAL_W-1:0] undef);
		drain_requests();
		cfg_we       <= 1'b1;
		cfg_wdata    <= undef;
		@(posedge clk);
		cfg_we       <= 1'b0;
		shadow_undef = undef;
		repeat (count) send_random(ins_pct);
	endtask

	initial begin
		logic [ktidl_pkg::KEY_W-1:0] k;
		int                          len;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.func         = ktidl_pkg::FN_LOOKUP;
		req_ch.key          = '0;
		req_ch.value        = '0;
		shadow_undef        = 32'hFFFF_FFFF;
		errors              = 0;
		rsp_seen            = 0;
		burst_left          = 0;
		steady_send         = 1'b0;
		hold_len            = 0;
		hold_serial         = 0;
		for (int p = 0; p < POOL_SIZE; p++) begin
			k   = '0;
			len = (p == 0) ? 0 : $urandom_range(1, ktidl_pkg::KEY_BYTES);
			for (int b = 0; b < len; b++) begin
				k[8*b +: 8] = 8'($urandom_range(1, 255));
			end
			key_pool[p] = k;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_table();
		test_backpressure();
		test_pause();
		test_random_mix(260, 45, 32'h8000_0000);
		test_random_mix(260, 25, 32'h7FFF_FFFF);
		test_random_mix(260, 40, 32'h0000_0000);
		test_random_mix(260, 30, $urandom());
		test_random_mix(260, 35, 32'hFFFF_FFFF);

		drain_requests();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// The response side stalls on its own pattern and serves long hold-offs.
	always @(posedge clk) begin
		if (hold_serial != hold_done) begin
			hold_done = hold_serial;
			hold_left = hold_len;
		end
		if (stretch_left <= 0) begin
			stretch_left = $urandom_range(8, 64);
			rx_mode      = $urandom_range(0, 3);
		end
		stretch_left--;
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0, 1: rsp_ch.ready <= 1'b1;
				2: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (rsp_due.size() == 0) begin
				report_mismatch("unexpected response", 64'h0, 64'h0);
			end else begin
				rsp_want = rsp_due.pop_front();
				if (rsp_ch.result_value !== rsp_want.result_value)
					report_mismatch("result_value", 64'(rsp_ch.result_value),
						64'(rsp_want.result_value));
				if (rsp_ch.found !== rsp_want.found)
					report_mismatch("found", 64'(rsp_ch.found), 64'(rsp_want.found));
				if (rsp_ch.status !== rsp_want.status)
					report_mismatch("status", 64'(rsp_ch.status), 64'(rsp_want.status));
				if (rsp_ch.entry_count !== rsp_want.entry_count)
					report_mismatch("entry_count", 64'(rsp_ch.entry_count),
						64'(rsp_want.entry_count));
				if (rsp_ch.is_empty !== rsp_want.is_empty)
					report_mismatch("is_empty", 64'(rsp_ch.is_empty), 64'(rsp_want.is_empty));
				if (rsp_ch.is_full !== rsp_want.is_full)
					report_mismatch("is_full", 64'(rsp_ch.is_full), 64'(rsp_want.is_full));
			end
			rsp_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
